// File: design/vdw_pair_energy_accumulator_assert.svh
// Assertion macros used by the pair energy accumulator datapath.
`ifndef VDW_PAIR_ENERGY_ACCUMULATOR_ASSERT_SVH
`define VDW_PAIR_ENERGY_ACCUMULATOR_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define VDW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define VDW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vdw_pkg.sv
// Types and constants of the van der Waals pair energy accumulator.
package vdw_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS  = 16;
    localparam int ENERGY_FRAC_BITS = 24;
    localparam int U_FRAC           = 24;
    localparam int MAG_SHIFT        = 36 - ENERGY_FRAC_BITS;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int PARM_W   = 16;
    localparam int CUTOFF_W = 32;
    localparam int PAIR_W   = 48;
    localparam int TOTAL_W  = 64;
    localparam int WORD_W   = 64;
    localparam int PROD_W   = 2 * WORD_W;

    // Distance and ratio widths
    localparam int SUMSQ_W    = 2 * COORD_W + 2;
    localparam int DSQ_W      = SUMSQ_W - COORD_FRAC_BITS;
    localparam int RSUM_W     = PARM_W + 1;
    localparam int RSQ_W      = 2 * RSUM_W;
    localparam int NUM_W      = RSQ_W + COORD_FRAC_BITS;
    localparam int DPROD_W    = 2 * PARM_W;
    localparam int SQRT_STEPS = PARM_W;
    localparam int ITER_RW    = ((DSQ_W > PARM_W + 2) ? DSQ_W : PARM_W + 2) + 1;
    localparam int ITER_CNT_W = $clog2(NUM_W + 1);

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CHECK,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DIFF,
        S_FIN
    } state_t;

    // Which product the shared multiplier is working on
    typedef enum logic [2:0] {
        M_SQ_X,
        M_SQ_Y,
        M_SQ_Z,
        M_UU,
        M_U3,
        M_U6,
        M_MAG
    } mstep_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_GO,
        OP_MUL_STORE,
        OP_CHECK,
        OP_SQRT_GO,
        OP_K_STORE,
        OP_DIV_GO,
        OP_U_STORE,
        OP_DIFF,
        OP_FINISH
    } dp_op_t;

    // Iterative unit mode
    typedef enum logic {
        IT_DIV,
        IT_SQRT
    } iter_mode_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        mstep_t mstep;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mul_done;
        logic iter_done;
        logic early_out;
        logic diff_sat;
        logic out_free;
    } stat_t;

endpackage

// File: design/vdw_intf.sv
// Handshake channel interfaces: pair items, result items and the cutoff register.
interface vdw_pair_if import vdw_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] z_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic signed [COORD_W-1:0] z_second;
    logic [PARM_W-1:0]         radius_first;
    logic [PARM_W-1:0]         radius_second;
    logic [PARM_W-1:0]         depth_first;
    logic [PARM_W-1:0]         depth_second;
    logic                      pair_enabled;
    logic                      last_pair;

    modport source (
        output valid, x_first, y_first, z_first, x_second, y_second, z_second,
               radius_first, radius_second, depth_first, depth_second,
               pair_enabled, last_pair,
        input  ready
    );
    modport sink (
        input  valid, x_first, y_first, z_first, x_second, y_second, z_second,
               radius_first, radius_second, depth_first, depth_second,
               pair_enabled, last_pair,
        output ready
    );
endinterface

interface vdw_result_if import vdw_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PAIR_W-1:0]  pair_energy;
    logic signed [TOTAL_W-1:0] total_energy;
    logic                      total_done;
    logic                      saturated;

    modport source (
        output valid, pair_energy, total_energy, total_done, saturated,
        input  ready
    );
    modport sink (
        input  valid, pair_energy, total_energy, total_done, saturated,
        output ready
    );
endinterface

interface vdw_cfg_if import vdw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CUTOFF_W-1:0] cutoff_sq;

    modport source (
        output valid, cutoff_sq,
        input  ready
    );
    modport sink (
        input  valid, cutoff_sq,
        output ready
    );
endinterface

// File: design/vdw_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier, one partial product at a time.
module vdw_mul import vdw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              busy,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    localparam int HALF_W = WORD_W / 2;

    logic [2:0]          phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   a_reg, b_reg;
    logic [WORD_W-1:0]   pp_reg;
    logic [1:0]          pos_reg;
    logic [PROD_W-1:0]   acc_reg;

    logic                pi, pj;
    logic [HALF_W-1:0]   a_half, b_half;
    logic [WORD_W-1:0]   pp;
    logic [PROD_W-1:0]   pp_shifted;

    // partial product select: phase bit 1 picks the a half, bit 0 the b half
    always_comb
    begin
        pi         = phase_reg[1];
        pj         = phase_reg[0];
        a_half     = pi ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half     = pj ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp         = a_half * b_half;
        pp_shifted = {{WORD_W{1'b0}}, pp_reg} << {pos_reg, 5'b0};
    end

    // sequencing
    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            phase_next = 3'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 3'd1;
            if (phase_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // operands, partial product register and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg != 3'd4)
            begin
                pp_reg  <= pp;
                pos_reg <= {1'b0, pi} + {1'b0, pj};
            end
            if (phase_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: design/vdw_iter.sv
// Bit-serial restoring divider that also runs an integer square root.
module vdw_iter import vdw_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  iter_mode_t       mode,
    input  logic [NUM_W-1:0] src,
    input  logic [DSQ_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic [ITER_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    iter_mode_t            mode_reg;
    logic [NUM_W-1:0]      src_reg;
    logic [DSQ_W-1:0]      den_reg;
    logic [ITER_RW-1:0]    rem_reg;
    logic [NUM_W-1:0]      quo_reg;

    logic [ITER_RW-1:0]    cand, trial, rem_step;
    logic                  ge;

    // one step: divide brings in one bit, square root brings in two
    always_comb
    begin
        if (mode_reg == IT_SQRT)
        begin
            cand  = {rem_reg[ITER_RW-3:0], src_reg[NUM_W-1 -: 2]};
            trial = ITER_RW'({quo_reg, 2'b01});
        end
        else
        begin
            cand  = {rem_reg[ITER_RW-2:0], src_reg[NUM_W-1]};
            trial = ITER_RW'(den_reg);
        end
        ge       = (cand >= trial);
        rem_step = ge ? (cand - trial) : cand;
    end

    // step counter
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = (mode == IT_SQRT) ? ITER_CNT_W'(SQRT_STEPS) : ITER_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            src_reg  <= src;
            den_reg  <= den;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            src_reg <= (mode_reg == IT_SQRT) ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: design/vdw_dp.sv
// Datapath: operand registers, shared arithmetic units, energy and running total.
module vdw_dp import vdw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output stat_t        stat,
    vdw_pair_if.sink     pair,
    vdw_result_if.source result,
    vdw_cfg_if.sink      cfg
);

`include "vdw_pair_energy_accumulator_assert.svh"

    localparam logic signed [PAIR_W-1:0]  PAIR_MAX  = {1'b0, {(PAIR_W-1){1'b1}}};
    localparam logic signed [PAIR_W-1:0]  PAIR_MIN  = {1'b1, {(PAIR_W-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic [WORD_W-1:0]         MAG_POS   = WORD_W'(PAIR_MAX);
    localparam logic [WORD_W-1:0]         MAG_NEG   = MAG_POS + 1'b1;

    // captured item
    logic signed [COORD_W-1:0] xf_reg, yf_reg, zf_reg, xs_reg, ys_reg, zs_reg;
    logic [PARM_W-1:0]         rf_reg, rs_reg, df_reg, ds_reg;
    logic                      en_reg, last_reg;

    // working values
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [PARM_W-1:0]   k_reg;
    logic [WORD_W-1:0]   u_reg, t_reg, mag_reg;
    logic                mag_ovf_reg, over_reg, neg_reg, zero_reg, sat_reg;

    // accumulation and output
    logic signed [TOTAL_W-1:0] running_total_reg, running_total_next;
    logic                      sat_seen_reg, sat_seen_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [PAIR_W-1:0]  pe_out_reg;
    logic signed [TOTAL_W-1:0] tot_out_reg;
    logic                      done_out_reg, satf_out_reg;

    // combinational
    logic signed [COORD_W-1:0] ca, cb;
    logic signed [COORD_W:0]   dlt;
    logic [COORD_W:0]          dlt_neg;
    logic [COORD_W-1:0]        abs_d;
    logic [RSUM_W-1:0]         rsum;
    logic [RSQ_W-1:0]          rsq;
    logic [DPROD_W-1:0]        dprod;
    logic [DSQ_W-1:0]          dsq;
    logic                      check_zero, check_sat;
    logic [WORD_W-1:0]         mul_a, mul_b;
    logic                      mul_start, mul_busy, mul_done;
    logic [PROD_W-1:0]         prod;
    logic [WORD_W-1:0]         shr_u, shr_m;
    logic                      ovf_u, ovf_m;
    logic                      iter_start, iter_busy, iter_done;
    iter_mode_t                iter_mode;
    logic [NUM_W-1:0]          iter_src, quo;
    logic [WORD_W-1:0]         two_u3;
    logic                      diff_sat;
    logic signed [PAIR_W-1:0]  pe;
    logic                      pe_sat;
    logic signed [TOTAL_W:0]   sum_wide;
    logic signed [TOTAL_W-1:0] tot;
    logic                      tot_sat;
    logic                      out_free;

    // coordinate difference for the axis in work
    always_comb
    begin
        case (cmd.mstep)
            M_SQ_X:
            begin
                ca = xf_reg;
                cb = xs_reg;
            end
            M_SQ_Y:
            begin
                ca = yf_reg;
                cb = ys_reg;
            end
            default:
            begin
                ca = zf_reg;
                cb = zs_reg;
            end
        endcase
        dlt     = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
        dlt_neg = -dlt;
        abs_d   = dlt[COORD_W] ? dlt_neg[COORD_W-1:0] : dlt[COORD_W-1:0];
    end

    // radius sum, its square, depth product, squared distance
    always_comb
    begin
        rsum  = {1'b0, rf_reg} + {1'b0, rs_reg};
        rsq   = rsum * rsum;
        dprod = df_reg * ds_reg;
        dsq   = sumsq_reg[SUMSQ_W-1:COORD_FRAC_BITS];
    end

    // early outcomes: zero energy ahead of the coincident-atom case
    always_comb
    begin
        check_zero = !en_reg
                     || ((cutoff_reg != '0) && (dsq > DSQ_W'(cutoff_reg)))
                     || (df_reg == '0) || (ds_reg == '0)
                     || (rsum == '0);
        check_sat  = !check_zero && (dsq == '0);
    end

    // multiplier operands
    always_comb
    begin
        case (cmd.mstep)
            M_SQ_X, M_SQ_Y, M_SQ_Z:
            begin
                mul_a = WORD_W'(abs_d);
                mul_b = WORD_W'(abs_d);
            end
            M_UU:
            begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
            M_U3:
            begin
                mul_a = t_reg;
                mul_b = u_reg;
            end
            M_U6:
            begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = WORD_W'(k_reg);
                mul_b = u_reg;
            end
        endcase
        mul_start = (cmd.op == OP_MUL_GO);
    end

    vdw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (prod)
    );

    // truncating shifts of the product with overflow past 64 bits
    always_comb
    begin
        shr_u = prod[U_FRAC +: WORD_W];
        ovf_u = |prod[PROD_W-1:U_FRAC+WORD_W];
        shr_m = prod[MAG_SHIFT +: WORD_W];
        ovf_m = |prod[PROD_W-1:MAG_SHIFT+WORD_W];
    end

    // divider / square root operands
    always_comb
    begin
        iter_start = (cmd.op == OP_SQRT_GO) || (cmd.op == OP_DIV_GO);
        iter_mode  = (cmd.op == OP_SQRT_GO) ? IT_SQRT : IT_DIV;
        if (cmd.op == OP_SQRT_GO)
        begin
            iter_src = {dprod, {(NUM_W-DPROD_W){1'b0}}};
        end
        else
        begin
            iter_src = {rsq, {COORD_FRAC_BITS{1'b0}}};
        end
    end

    vdw_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (iter_start),
        .mode  (iter_mode),
        .src   (iter_src),
        .den   (dsq),
        .busy  (iter_busy),
        .done  (iter_done),
        .quo   (quo)
    );

    // u^6 - 2u^3 stage
    always_comb
    begin
        two_u3   = {t_reg[WORD_W-2:0], 1'b0};
        diff_sat = over_reg || t_reg[WORD_W-1];
    end

    // pair energy with clamping
    always_comb
    begin
        pe     = '0;
        pe_sat = 1'b0;
        if (zero_reg)
        begin
            pe = '0;
        end
        else if (sat_reg)
        begin
            pe     = PAIR_MAX;
            pe_sat = 1'b1;
        end
        else if (neg_reg)
        begin
            if (mag_ovf_reg || (mag_reg > MAG_NEG))
            begin
                pe     = PAIR_MIN;
                pe_sat = 1'b1;
            end
            else
            begin
                pe = -$signed(mag_reg[PAIR_W-1:0]);
            end
        end
        else
        begin
            if (mag_ovf_reg || (mag_reg > MAG_POS))
            begin
                pe     = PAIR_MAX;
                pe_sat = 1'b1;
            end
            else
            begin
                pe = $signed(mag_reg[PAIR_W-1:0]);
            end
        end
    end

    // running total with clamping
    always_comb
    begin
        sum_wide = {running_total_reg[TOTAL_W-1], running_total_reg}
                   + (TOTAL_W+1)'(pe);
        tot_sat  = (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]);
        if (!tot_sat)
        begin
            tot = sum_wide[TOTAL_W-1:0];
        end
        else if (sum_wide[TOTAL_W])
        begin
            tot = TOTAL_MIN;
        end
        else
        begin
            tot = TOTAL_MAX;
        end
    end

    // accumulator and output handshake next values
    always_comb
    begin
        out_free           = !out_valid_reg || result.ready;
        running_total_next = running_total_reg;
        sat_seen_next      = sat_seen_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        if (cmd.op == OP_FINISH)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                running_total_next = '0;
                sat_seen_next      = 1'b0;
            end
            else
            begin
                running_total_next = tot;
                sat_seen_next      = sat_seen_reg || pe_sat || tot_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg        <= '0;
            running_total_reg <= '0;
            sat_seen_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cutoff_reg <= cfg.cutoff_sq;
            end
            running_total_reg <= running_total_next;
            sat_seen_reg      <= sat_seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // item capture and working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                xf_reg    <= pair.x_first;
                yf_reg    <= pair.y_first;
                zf_reg    <= pair.z_first;
                xs_reg    <= pair.x_second;
                ys_reg    <= pair.y_second;
                zs_reg    <= pair.z_second;
                rf_reg    <= pair.radius_first;
                rs_reg    <= pair.radius_second;
                df_reg    <= pair.depth_first;
                ds_reg    <= pair.depth_second;
                en_reg    <= pair.pair_enabled;
                last_reg  <= pair.last_pair;
                sumsq_reg <= '0;
                over_reg  <= 1'b0;
                zero_reg  <= 1'b0;
                sat_reg   <= 1'b0;
            end
            OP_MUL_STORE:
            begin
                case (cmd.mstep)
                    M_SQ_X, M_SQ_Y, M_SQ_Z:
                    begin
                        sumsq_reg <= sumsq_reg + SUMSQ_W'(prod[WORD_W-1:0]);
                    end
                    M_UU, M_U3:
                    begin
                        t_reg    <= shr_u;
                        over_reg <= over_reg || ovf_u;
                    end
                    M_U6:
                    begin
                        u_reg    <= shr_u;
                        over_reg <= over_reg || ovf_u;
                    end
                    default:
                    begin
                        mag_reg     <= shr_m;
                        mag_ovf_reg <= ovf_m;
                    end
                endcase
            end
            OP_CHECK:
            begin
                zero_reg <= check_zero;
                sat_reg  <= check_sat;
            end
            OP_K_STORE:
            begin
                k_reg <= quo[PARM_W-1:0];
            end
            OP_U_STORE:
            begin
                u_reg <= WORD_W'(quo);
            end
            OP_DIFF:
            begin
                if (diff_sat)
                begin
                    sat_reg <= 1'b1;
                end
                else if (u_reg >= two_u3)
                begin
                    neg_reg <= 1'b0;
                    u_reg   <= u_reg - two_u3;
                end
                else
                begin
                    neg_reg <= 1'b1;
                    u_reg   <= two_u3 - u_reg;
                end
            end
            OP_FINISH:
            begin
                pe_out_reg   <= pe;
                tot_out_reg  <= tot;
                done_out_reg <= last_reg;
                satf_out_reg <= sat_seen_reg || pe_sat || tot_sat;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    always_comb
    begin
        stat.mul_done  = mul_done;
        stat.iter_done = iter_done;
        stat.early_out = check_zero || check_sat;
        stat.diff_sat  = diff_sat;
        stat.out_free  = out_free;
    end

    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.pair_energy  = pe_out_reg;
    assign result.total_energy = tot_out_reg;
    assign result.total_done   = done_out_reg;
    assign result.saturated    = satf_out_reg;

    // checks
    `VDW_ASSERT_IMPLIES(a_mul_idle, cmd.op == OP_MUL_GO, !mul_busy, "multiplier started while busy")
    `VDW_ASSERT_IMPLIES(a_iter_idle, iter_start, !iter_busy, "divider started while busy")
    `VDW_ASSERT_IMPLIES(a_div_nonzero, cmd.op == OP_DIV_GO, dsq != '0, "divide by zero distance")
    `VDW_ASSERT_IMPLIES(a_finish_room, cmd.op == OP_FINISH, out_free, "result overwritten")
    `VDW_ASSERT_NEXT(a_sum_clears, (cmd.op == OP_FINISH) && last_reg, (running_total_reg == '0) && !sat_seen_reg, "sum not cleared after last pair")

endmodule

// File: design/vdw_ctrl.sv
// Sequencer that steps one pair through the shared multiplier and divider.
module vdw_ctrl import vdw_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    mstep_t step_reg, step_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL_GO;
                    step_next  = M_SQ_X;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    case (step_reg)
                        M_SQ_X:
                        begin
                            step_next  = M_SQ_Y;
                            state_next = S_MUL_GO;
                        end
                        M_SQ_Y:
                        begin
                            step_next  = M_SQ_Z;
                            state_next = S_MUL_GO;
                        end
                        M_SQ_Z:
                        begin
                            state_next = S_CHECK;
                        end
                        M_UU:
                        begin
                            step_next  = M_U3;
                            state_next = S_MUL_GO;
                        end
                        M_U3:
                        begin
                            step_next  = M_U6;
                            state_next = S_MUL_GO;
                        end
                        M_U6:
                        begin
                            state_next = S_DIFF;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                state_next = stat.early_out ? S_FIN : S_SQRT_GO;
            end
            S_SQRT_GO:
            begin
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (stat.iter_done)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.iter_done)
                begin
                    state_next = S_MUL_GO;
                    step_next  = M_UU;
                end
            end
            S_DIFF:
            begin
                if (stat.diff_sat)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MUL_GO;
                    step_next  = M_MAG;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.op    = OP_NONE;
        cmd.mstep = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_MUL_GO:
            begin
                cmd.op = OP_MUL_GO;
            end
            S_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op = OP_MUL_STORE;
                end
            end
            S_CHECK:
            begin
                cmd.op = OP_CHECK;
            end
            S_SQRT_GO:
            begin
                cmd.op = OP_SQRT_GO;
            end
            S_SQRT_WAIT:
            begin
                if (stat.iter_done)
                begin
                    cmd.op = OP_K_STORE;
                end
            end
            S_DIV_GO:
            begin
                cmd.op = OP_DIV_GO;
            end
            S_DIV_WAIT:
            begin
                if (stat.iter_done)
                begin
                    cmd.op = OP_U_STORE;
                end
            end
            S_DIFF:
            begin
                cmd.op = OP_DIFF;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_FINISH;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= M_SQ_X;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: design/vdw_pair_energy_accumulator.sv
// Top level of the van der Waals pair energy accumulator.
// Each pair item yields one result item: the 12-6 pair energy in Q24.24, the
// running total including it, a done mark echoing last_pair and a sticky
// saturation flag; the total and flag clear after a last pair. One pair is
// worked at a time. A pair that runs the full chain has its result registered
// after seven passes through the shared 64x64 multiplier (one 32x32 multiplier
// working one partial product at a time), a 16-step square root and a 50-step
// bit-serial divide, plus the range check, the u^6 - 2u^3 step and the finish.
// A pair whose u^3 or u^6 overflows skips the last multiply. A pair that is
// disabled, cut off, has a zero depth or radius sum, or sits on its partner
// finishes after the three distance squares. A stalled result adds its stall
// time. The result waits in an output register, and the next pair is accepted
// as soon as the previous result is registered. The cutoff register may be
// written at any time the block is idle; its channel is always ready.
module vdw_pair_energy_accumulator import vdw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    vdw_pair_if.sink     pair,
    vdw_result_if.source result,
    vdw_cfg_if.sink      cfg
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    vdw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pair.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vdw_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .pair   (pair),
        .result (result),
        .cfg    (cfg)
    );

    assign pair.ready = in_ready;

endmodule

// File: bench/vdw_pair_energy_accumulator_test.sv
// Self-checking bench for the van der Waals pair energy accumulator.
`timescale 1ns / 100ps
module vdw_pair_energy_accumulator_test;
    import vdw_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] xa, ya, za, xb, yb, zb;
        logic [PARM_W-1:0]         ra, rb, ka, kb;
        logic                      en, last;
    } pair_t;

    typedef struct {
        logic signed [PAIR_W-1:0]  pe;
        logic signed [TOTAL_W-1:0] tot;
        logic                      done;
        logic                      sat;
    } energy_t;

    // Directed row: pair plus optional typed-in expected pair energy
    typedef struct {
        pair_t                    p;
        bit                       known;
        logic signed [PAIR_W-1:0] pe;
    } row_t;

    localparam logic signed [63:0] PMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] PMIN = -PMAX - 1;
    localparam logic signed [63:0] TMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] TMIN = 64'sh8000_0000_0000_0000;

    logic clk;
    logic rst_n;

    vdw_pair_if   pair ();
    vdw_result_if result ();
    vdw_cfg_if    cfg ();

    vdw_pair_energy_accumulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Predictor state
    logic [CUTOFF_W-1:0]       cut_model;
    logic signed [TOTAL_W-1:0] sum_model;
    logic                      sat_model;

    energy_t energy_q[$];
    int      errors;
    int      results_seen;
    int      sat_seen;
    int      done_seen;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Saturating floor(a*b >> sh)
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                               input int sh, inout bit ovf);
        logic [127:0] prod;
        prod = a * b;
        prod = prod >> sh;
        if (prod[127:64] != 0)
        begin
            ovf = 1'b1;
            return '1;
        end
        return prod[63:0];
    endfunction

    // Integer square root by bisection on a 32-bit argument
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] lo, hi, mid;
        lo = 0;
        hi = 64'd65536;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Pair energy of one item; sets sat on any clamp
    function automatic logic signed [63:0] lj_energy(input pair_t p, inout bit sat);
        logic signed [63:0] d;
        logic [65:0]  sumsq;
        logic [63:0]  dsq, k, r, u, u3, u6, diff, mag;
        logic [127:0] num;
        bit           ovf, neg;
        ovf = 0;
        sumsq = 0;
        d = 64'(p.xa) - 64'(p.xb); if (d < 0) d = -d; sumsq += 66'(d) * 66'(d);
        d = 64'(p.ya) - 64'(p.yb); if (d < 0) d = -d; sumsq += 66'(d) * 66'(d);
        d = 64'(p.za) - 64'(p.zb); if (d < 0) d = -d; sumsq += 66'(d) * 66'(d);
        dsq = 64'(sumsq >> COORD_FRAC_BITS);
        if (cut_model != 0 && dsq > 64'(cut_model))
            return 0;
        k = int_root(64'(p.ka) * 64'(p.kb));
        if (k == 0)
            return 0;
        r = 64'(p.ra) + 64'(p.rb);
        if (r == 0)
            return 0;
        if (dsq == 0)
        begin
            sat = 1;
            return PMAX;
        end
        num = 128'(r * r) << COORD_FRAC_BITS;
        u = 64'(num / dsq);
        u3 = mul_shift(mul_shift(u, u, U_FRAC, ovf), u, U_FRAC, ovf);
        u6 = mul_shift(u3, u3, U_FRAC, ovf);
        if (ovf || u3[63])
        begin
            sat = 1;
            return PMAX;
        end
        neg = u6 < 2 * u3;
        diff = neg ? 2 * u3 - u6 : u6 - 2 * u3;
        mag = mul_shift(k, diff, MAG_SHIFT, ovf);
        if (neg)
        begin
            if (ovf || mag > 64'(PMAX) + 1)
            begin
                sat = 1;
                return PMIN;
            end
            return -$signed(mag);
        end
        if (ovf || mag > 64'(PMAX))
        begin
            sat = 1;
            return PMAX;
        end
        return $signed(mag);
    endfunction

    // Predict one result and advance the running sum
    function automatic energy_t accumulate(input pair_t p);
        energy_t e;
        bit sat;
        logic signed [63:0] pe, t;
        sat = 0;
        pe = p.en ? lj_energy(p, sat) : 64'sd0;
        t = sum_model;
        if (pe > 0 && t > TMAX - pe)
        begin
            t = TMAX;
            sat = 1;
        end
        else if (pe < 0 && t < TMIN - pe)
        begin
            t = TMIN;
            sat = 1;
        end
        else
            t = t + pe;
        sat_model = sat_model | sat;
        e.pe = pe[PAIR_W-1:0];
        e.tot = t;
        e.done = p.last;
        e.sat = sat_model;
        sum_model = p.last ? 64'sd0 : t;
        if (p.last)
            sat_model = 0;
        return e;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int mode;
        mode = $urandom_range(0, 9);
        p.xa = $urandom; p.ya = $urandom; p.za = $urandom;
        if (mode < 7)
        begin
            // near-contact geometry, a few angstroms apart
            p.xb = p.xa + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            p.yb = p.ya + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            p.zb = p.za + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            p.ra = 16'($urandom_range(2000, 12000));
            p.rb = 16'($urandom_range(2000, 12000));
            p.ka = 16'($urandom_range(0, 8000));
            p.kb = 16'($urandom_range(0, 8000));
        end
        else
        begin
            p.xb = $urandom; p.yb = $urandom; p.zb = $urandom;
            p.ra = 16'($urandom); p.rb = 16'($urandom);
            p.ka = 16'($urandom); p.kb = 16'($urandom);
        end
        if (mode == 9)
        begin
            p.xb = p.xa; p.yb = p.ya; p.zb = p.za;
        end
        p.en = $urandom_range(0, 9) != 0;
        p.last = $urandom_range(0, 7) == 0;
        return p;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Send one pair item, expectation queued at acceptance
    task automatic send_pair(input pair_t p, input bit known, input logic signed [PAIR_W-1:0] pe);
        energy_t e;
        int      n;
        pair.valid         <= 1'b1;
        pair.x_first       <= p.xa; pair.y_first  <= p.ya; pair.z_first  <= p.za;
        pair.x_second      <= p.xb; pair.y_second <= p.yb; pair.z_second <= p.zb;
        pair.radius_first  <= p.ra; pair.radius_second <= p.rb;
        pair.depth_first   <= p.ka; pair.depth_second  <= p.kb;
        pair.pair_enabled  <= p.en; pair.last_pair     <= p.last;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        e = accumulate(p);
        if (known && e.pe !== pe)
        begin
            $error("table pair_energy: expected %0d, model %0d", pe, e.pe);
            errors++;
        end
        energy_q.push_back(e);
        // with no gap valid stays high for the next item
        n = ($urandom_range(0, 4) == 0) ? 0 : gap_len();
        if (n != 0)
        begin
            pair.valid <= 1'b0;
            repeat (n)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        pair.valid <= 1'b0;
        while (energy_q.size() != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    task automatic write_cutoff(input logic [CUTOFF_W-1:0] v);
        drain();
        cfg.valid     <= 1'b1;
        cfg.cutoff_sq <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cut_model = v;
    endtask

    // Result checking and random back-pressure
    always @(posedge clk)
    begin
        energy_t e;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (result.saturated) sat_seen++;
                if (result.total_done) done_seen++;
                if (energy_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    e = energy_q.pop_front();
                    if (result.pair_energy !== e.pe)
                    begin
                        $error("pair_energy: expected %0d, actual %0d", e.pe, result.pair_energy);
                        errors++;
                    end
                    if (result.total_energy !== e.tot)
                    begin
                        $error("total_energy: expected %0d, actual %0d", e.tot,
                               result.total_energy);
                        errors++;
                    end
                    if (result.total_done !== e.done)
                    begin
                        $error("total_done: expected %0b, actual %0b", e.done, result.total_done);
                        errors++;
                    end
                    if (result.saturated !== e.sat)
                    begin
                        $error("saturated: expected %0b, actual %0b", e.sat, result.saturated);
                        errors++;
                    end
                end
            end
            result.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    // Limit
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        row_t  rows[$];
        row_t  r;
        pair_t base;
        logic [CUTOFF_W-1:0] cuts[4];
        errors = 0; results_seen = 0; sat_seen = 0; done_seen = 0;
        cut_model = 0; sum_model = 0; sat_model = 0;
        rst_n = 1'b0;
        pair.valid = 1'b0;
        pair.x_first = 0; pair.y_first = 0; pair.z_first = 0;
        pair.x_second = 0; pair.y_second = 0; pair.z_second = 0;
        pair.radius_first = 0; pair.radius_second = 0;
        pair.depth_first = 0; pair.depth_second = 0;
        pair.pair_enabled = 0; pair.last_pair = 0;
        result.ready = 1'b0;
        cfg.valid = 1'b0; cfg.cutoff_sq = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: 3 A contact pair as base
        base = '{xa: 0, ya: 0, za: 0, xb: 32'sd3 << 16, yb: 0, zb: 0,
                 ra: 16'h1800, rb: 16'h1800, ka: 16'h1000, kb: 16'h1000, en: 1, last: 0};
        r.p = base; r.known = 0; r.pe = 0;
        rows.push_back(r);                                  // at the well minimum
        r.p.en = 0; r.known = 1; rows.push_back(r);         // disabled
        r.p = base; r.p.ka = 0; rows.push_back(r);          // zero depth
        r.p = base; r.p.ra = 0; r.p.rb = 0; rows.push_back(r);  // zero radius sum
        r.p = base; r.p.xb = 0; r.p.ra = 0; r.p.rb = 0; rows.push_back(r); // coincident, r zero
        r.p = base; r.p.xb = 0; r.pe = PMAX[PAIR_W-1:0]; rows.push_back(r); // coincident
        r.p = base; r.p.xb = 32'sd1 << 12; r.p.ra = '1; r.p.rb = '1; rows.push_back(r); // overflow
        r.p = base; r.p.last = 1; r.known = 0; rows.push_back(r);
        // coordinate extremes, far apart
        r.p = base; r.p.xa = 32'sh8000_0000; r.p.ya = 32'sh8000_0000; r.p.za = 32'sh8000_0000;
        r.p.xb = 32'sh7FFF_FFFF; r.p.yb = 32'sh7FFF_FFFF; r.p.zb = 32'sh7FFF_FFFF;
        r.p.ra = '1; r.p.rb = '1; r.p.ka = '1; r.p.kb = '1; rows.push_back(r);
        r.p = base; r.p.xb = 32'sd1 << 16; r.p.ka = '1; r.p.kb = '1; rows.push_back(r); // repulsive
        r.p = base; r.p.xb = 32'sd4 << 16; rows.push_back(r);   // attractive
        // raise the saturation flag with repeated clamped pairs
        r.p = base; r.p.xb = 0; r.known = 1; r.pe = PMAX[PAIR_W-1:0];
        repeat (3) rows.push_back(r);
        r.p.last = 1; rows.push_back(r);

        foreach (rows[i])
            send_pair(rows[i].p, rows[i].known, rows[i].pe);

        // Hold off until all results are in
        drain();

        // Random part across cutoff settings, extremes included
        cuts[0] = 32'd1 << 16;
        cuts[1] = '1;
        cuts[2] = 32'd16 << 16;
        cuts[3] = 0;
        foreach (cuts[c])
        begin
            write_cutoff(cuts[c]);
            if (c == 0)
                send_pair(base, 1, 0);     // 9 A^2 beyond a 1 A^2 cutoff
            repeat (275)
                send_pair(rand_pair(), 0, 0);
        end

        drain();
        $display("Covered %0d result items over 4 distinct cutoff settings, %0d sums closed,",
                 results_seen, done_seen);
        $display("%0d results with the saturation flag raised.", sat_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/vdw_pkg.sv
design/vdw_intf.sv
design/vdw_mul.sv
design/vdw_iter.sv
design/vdw_dp.sv
design/vdw_ctrl.sv
design/vdw_pair_energy_accumulator.sv
bench/vdw_pair_energy_accumulator_test.sv
